/* hw/rtl/lcgbr_pkg.sv */
// package for the bounded 48-bit lcg random core
// constants, controller/datapath command and status structs
// no dependencies
package lcgbr_pkg;

    localparam int unsigned STATE_W  = 48;
    localparam int unsigned VALUE_W  = 31;
    localparam int unsigned LIMB_W   = 16;
    localparam int unsigned MUL_LIMBS = STATE_W / LIMB_W;
    localparam int unsigned DIV_STEPS = VALUE_W;
    localparam int unsigned CNT_W    = 5;
    localparam int unsigned MULT_W   = 35;
    localparam int unsigned PP_W     = LIMB_W + MULT_W;

    localparam logic [MULT_W-1:0]  LCG_MULT = 35'h5_DEEC_E66D;
    localparam logic [STATE_W-1:0] LCG_ADD  = 48'h0000_0000_000B;

    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MUL_LIMBS - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

    typedef struct packed {
        logic       load_in;
        logic       mul_en;
        logic [1:0] mul_idx;
        logic       div_start;
        logic       div_step;
        logic       p2_en;
        logic       take_rem;
        logic       load_out;
    } cmd_t;

    typedef struct packed {
        logic is_p2;
        logic test_neg;
    } sts_t;

endpackage

/* hw/rtl/lcg48_bounded_random_core.sv */
// top level of the bounded 48-bit lcg random core
// instantiates lcgbr_ctrl and lcgbr_dp; uses lcgbr_pkg
//
// channel    | direction | fields (low bit up)          | handshake
// -----------+-----------+------------------------------+------------------
// s_*        | in        | tdata: bound[30:0], pad[31]  | s_tvalid/s_tready
// m_*        | out       | tdata: value[30:0], pad[31]  | m_tvalid/m_tready
// seed_*     | in        | seed_wdata: seed[47:0]       | seed_we, no wait
//
// one item at a time: accept, a limb-serial 48x35 multiply for the lcg step, a select
// state (holds the 31x31 multiply for a power-of-two bound), else a restoring divider
// and a test state that redraws a rejected draw, then the load of the output register
// asynchronous active-low reset puts the state at 0x5DEECE66D (seed of zero)
// a stalled result is held; the next item is accepted but its result waits
module lcg48_bounded_random_core (
    input  logic        clk,
    input  logic        rst_n,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [30:0] bound, [31] zero
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [30:0] value, [31] zero
    // seed register write
    input  logic        seed_we,
    input  logic [47:0] seed_wdata
);

    lcgbr_pkg::cmd_t               cmd;
    lcgbr_pkg::sts_t               sts;
    logic [lcgbr_pkg::VALUE_W-1:0] value;

    // state machine: handshakes, draw/divide sequencing, rejection loop
    lcgbr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: generator state, multiplier, divider, result registers
    lcgbr_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .bound_in   (s_tdata[lcgbr_pkg::VALUE_W-1:0]),
        .seed_we    (seed_we),
        .seed_wdata (seed_wdata),
        .value_out  (value)
    );

    // pad to whole bytes
    assign m_tdata = {1'b0, value};

endmodule

/* hw/rtl/lcgbr_dp.sv */
// datapath: lcg state, limb-serial constant multiply, restoring divider,
// power-of-two multiply, result and output registers; uses lcgbr_pkg
module lcgbr_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  lcgbr_pkg::cmd_t                 cmd,
    output lcgbr_pkg::sts_t                 sts,
    input  logic [lcgbr_pkg::VALUE_W-1:0]   bound_in,
    input  logic                            seed_we,
    input  logic [lcgbr_pkg::STATE_W-1:0]   seed_wdata,
    output logic [lcgbr_pkg::VALUE_W-1:0]   value_out
);

    logic [lcgbr_pkg::STATE_W-1:0] state_reg;
    logic [lcgbr_pkg::STATE_W-1:0] acc_reg;
    logic [lcgbr_pkg::STATE_W-1:0] acc_next;
    logic [lcgbr_pkg::VALUE_W-1:0] bound_reg;
    logic [lcgbr_pkg::VALUE_W-1:0] u_reg;
    logic [lcgbr_pkg::VALUE_W-1:0] rem_reg;
    logic [lcgbr_pkg::VALUE_W-1:0] rem_next;
    logic [lcgbr_pkg::VALUE_W-1:0] dsh_reg;
    logic [lcgbr_pkg::VALUE_W-1:0] res_reg;
    logic [lcgbr_pkg::VALUE_W-1:0] out_reg;
    logic [lcgbr_pkg::LIMB_W-1:0]  limb;
    logic [lcgbr_pkg::PP_W-1:0]    pp;
    logic [lcgbr_pkg::STATE_W-1:0] pp_sh;
    logic [lcgbr_pkg::VALUE_W:0]   trial;
    logic [lcgbr_pkg::VALUE_W-1:0] bound_m1;
    logic [lcgbr_pkg::VALUE_W:0]   sum;
    logic [2*lcgbr_pkg::VALUE_W-1:0] prod;

    // one 16-bit limb of the state times the multiplier per cycle
    always_comb
    begin
        case (cmd.mul_idx)
            2'd0:    limb = state_reg[15:0];
            2'd1:    limb = state_reg[31:16];
            2'd2:    limb = state_reg[47:32];
            default: limb = '0;
        endcase
        pp = {{lcgbr_pkg::MULT_W{1'b0}}, limb} * {{lcgbr_pkg::LIMB_W{1'b0}}, lcgbr_pkg::LCG_MULT};
        case (cmd.mul_idx)
            2'd0:    pp_sh = pp[47:0];
            2'd1:    pp_sh = {pp[31:0], 16'h0000};
            2'd2:    pp_sh = {pp[15:0], 32'h0000_0000};
            default: pp_sh = '0;
        endcase
        acc_next = ((cmd.mul_idx == 2'd0) ? lcgbr_pkg::LCG_ADD : acc_reg) + pp_sh;
    end

    // restoring divide step, remainder only
    always_comb
    begin
        trial = {rem_reg, dsh_reg[lcgbr_pkg::VALUE_W-1]};
        if (trial >= {1'b0, bound_reg})
            rem_next = lcgbr_pkg::VALUE_W'(trial - {1'b0, bound_reg});
        else
            rem_next = trial[lcgbr_pkg::VALUE_W-1:0];
    end

    assign bound_m1 = bound_reg - lcgbr_pkg::VALUE_W'(1);
    // 32-bit wrapping u - r + (bound - 1), sign bit decides rejection
    assign sum  = {1'b0, u_reg} - {1'b0, rem_reg} + {1'b0, bound_m1};
    assign prod = {{lcgbr_pkg::VALUE_W{1'b0}}, bound_reg} * {{lcgbr_pkg::VALUE_W{1'b0}}, u_reg};

    assign sts.is_p2    = ((bound_reg & bound_m1) == '0);
    assign sts.test_neg = sum[lcgbr_pkg::VALUE_W];
    assign value_out    = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= {{(lcgbr_pkg::STATE_W-lcgbr_pkg::MULT_W){1'b0}}, lcgbr_pkg::LCG_MULT};
        end
        else if (seed_we)
        begin
            state_reg <= seed_wdata
                ^ {{(lcgbr_pkg::STATE_W-lcgbr_pkg::MULT_W){1'b0}}, lcgbr_pkg::LCG_MULT};
        end
        else if (cmd.mul_en && (cmd.mul_idx == 2'd2))
        begin
            state_reg <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
            bound_reg <= bound_in;
        if (cmd.mul_en)
            acc_reg <= acc_next;
        if (cmd.mul_en && (cmd.mul_idx == 2'd2))
            u_reg <= acc_next[lcgbr_pkg::STATE_W-1:lcgbr_pkg::STATE_W-lcgbr_pkg::VALUE_W];
        if (cmd.div_start)
        begin
            rem_reg <= '0;
            dsh_reg <= u_reg;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            dsh_reg <= {dsh_reg[lcgbr_pkg::VALUE_W-2:0], 1'b0};
        end
        if (cmd.p2_en)
            res_reg <= prod[2*lcgbr_pkg::VALUE_W-1:lcgbr_pkg::VALUE_W];
        else if (cmd.take_rem)
            res_reg <= rem_reg;
        if (cmd.load_out)
            out_reg <= res_reg;
    end

endmodule

/* hw/rtl/lcgbr_ctrl.sv */
// controller: sequences draw, divide, rejection test and output handoff
// uses lcgbr_pkg command and status structs
module lcgbr_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    input  lcgbr_pkg::sts_t sts,
    output lcgbr_pkg::cmd_t cmd
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_DRAW = 6'b000010,
        ST_SEL  = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_TEST = 6'b010000,
        ST_DONE = 6'b100000
    } state_t;

    state_t                      state_reg, state_next;
    logic [lcgbr_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                        out_valid_reg, out_valid_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cmd            = '0;
        cmd.mul_idx    = cnt_reg[1:0];
        out_valid_next = out_valid_reg && !m_tready;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    cnt_next    = '0;
                    state_next  = ST_DRAW;
                end
            end
            ST_DRAW:
            begin
                cmd.mul_en = 1'b1;
                if (cnt_reg == lcgbr_pkg::MUL_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_SEL;
                end
                else
                begin
                    cnt_next = cnt_reg + lcgbr_pkg::CNT_W'(1);
                end
            end
            ST_SEL:
            begin
                if (sts.is_p2)
                begin
                    cmd.p2_en  = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cnt_next      = '0;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == lcgbr_pkg::DIV_LAST)
                    state_next = ST_TEST;
                else
                    cnt_next = cnt_reg + lcgbr_pkg::CNT_W'(1);
            end
            ST_TEST:
            begin
                cnt_next = '0;
                if (sts.test_neg)
                begin
                    state_next = ST_DRAW;
                end
                else
                begin
                    cmd.take_rem = 1'b1;
                    state_next   = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* hw/rtl/lcgbr_checker.sv */
// port-level checker for lcg48_bounded_random_core, bound to the top level
// depends on the top level's port list only
module lcgbr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // a held result keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one item at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted twice in a row");

    // ready only drops because an item came in
    a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) |-> $past(s_tvalid))
        else $error("ready dropped without an accepted item");

    // results stay in 31 bits
    a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[31] == 1'b0))
        else $error("result pad bit set");

endmodule

bind lcg48_bounded_random_core lcgbr_checker u_lcgbr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
);

/* test/lcg48_bounded_random_checker.sv */
`timescale 1ns / 100ps
// checker for the bounded 48-bit lcg random core: watches the item channels and
// seed writes, predicts every value and compares it; needs no rtl package
module lcg48_bounded_random_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,    // [30:0] bound, [31] zero
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,    // [30:0] value, [31] zero
    input  logic        seed_we,
    input  logic [47:0] seed_wdata,
    output int          fail_count,
    output int          pending,
    output int          result_count,
    output int          redraw_count,
    output int          pow2_count
);

    localparam logic [47:0] GEN_MULT   = 48'h0005_DEEC_E66D;
    localparam logic [47:0] GEN_INC    = 48'h0000_0000_000B;
    localparam int          REPORT_MAX = 10;

    logic [47:0] gen_state;
    logic [30:0] bounded_values [$];
    logic [30:0] want_value;
    int          errs;
    int          results;
    int          redraws;
    int          pow2s;

    function automatic logic [30:0] step_draw();
        gen_state = gen_state * GEN_MULT + GEN_INC;
        return gen_state[47:17];
    endfunction

    function automatic logic [30:0] bounded_draw(input logic [30:0] bound);
        logic [31:0] lim;
        logic [31:0] lim_m1;
        logic [31:0] u;
        logic [31:0] r;
        logic [31:0] sum;
        logic [61:0] prod;
        logic [30:0] first;
        first  = step_draw();
        lim    = {1'b0, bound};
        lim_m1 = lim - 32'd1;
        // zero counts as a power of two here
        if ((lim & lim_m1) == 32'd0)
        begin
            pow2s++;
            prod = {31'd0, bound} * {31'd0, first};
            return prod[61:31];
        end
        u   = {1'b0, first};
        r   = u % lim;
        sum = u - r + lim_m1;
        // redraw while the wrapped sum is negative
        while (sum[31])
        begin
            redraws++;
            u   = {1'b0, step_draw()};
            r   = u % lim;
            sum = u - r + lim_m1;
        end
        return r[30:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_state = GEN_MULT;
            bounded_values.delete();
            errs    = 0;
            results = 0;
            redraws = 0;
            pow2s   = 0;
        end
        else
        begin
            if (seed_we)
                gen_state = seed_wdata ^ GEN_MULT;
            if (s_tvalid && s_tready)
                bounded_values = {bounded_values, bounded_draw(s_tdata[30:0])};
            if (m_tvalid && m_tready)
            begin
                if (bounded_values.size() == 0)
                begin
                    errs++;
                    if (errs <= REPORT_MAX)
                        $display("%0t: unexpected result item, value %h", $realtime,
                                 m_tdata);
                end
                else
                begin
                    want_value = bounded_values.pop_front();
                    results++;
                    if (m_tdata[30:0] !== want_value || m_tdata[31] !== 1'b0)
                    begin
                        errs++;
                        if (errs <= REPORT_MAX)
                            $display("%0t: value mismatch, expected %h got %h (pad %b)",
                                     $realtime, want_value, m_tdata[30:0], m_tdata[31]);
                    end
                end
            end
        end
        fail_count   <= errs;
        pending      <= bounded_values.size();
        result_count <= results;
        redraw_count <= redraws;
        pow2_count   <= pow2s;
    end

endmodule

/* test/tb_lcg48_bounded_random_core.sv */
`timescale 1ns / 100ps
// testbench top for lcg48_bounded_random_core: drives bound items and seed writes,
// stalls the result side, and gives the verdict; uses lcg48_bounded_random_checker
module tb_lcg48_bounded_random_core;

    localparam int          NUM_PHASES     = 8;
    localparam int          ITEMS_PER_PHASE = 210;
    localparam int          WATCHDOG_LIMIT = 20000;
    localparam int          SETTLE_CYCLES  = 60;
    // this seed makes the reloaded state exactly zero
    localparam logic [47:0] SEED_ZERO_STATE = 48'h0005_DEEC_E66D;
    localparam logic [47:0] SEED_ALL_ONES   = 48'hFFFF_FFFF_FFFF;

    // edge bounds: zero, one, powers of two, just past a power of two (heavy
    // rejection), the largest bounds and alternating bit patterns
    localparam logic [30:0] CORNER_BOUNDS [21] = '{
        31'd0, 31'd1, 31'd2, 31'd3, 31'd4, 31'd5, 31'd6, 31'd7,
        31'd100, 31'd1000, 31'd65536, 31'd1000000,
        31'h4000_0000, 31'h4000_0001, 31'h3FFF_FFFF, 31'h4000_0003,
        31'h5555_5555, 31'h2AAA_AAAA, 31'h7FFF_FFFE, 31'h7FFF_FFFF,
        31'h1234_5678
    };

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;     // [30:0] bound, [31] zero
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;     // [30:0] value, [31] zero
    logic        seed_we;
    logic [47:0] seed_wdata;

    int fail_count;
    int pending;
    int result_count;
    int redraw_count;
    int pow2_count;

    // sender bookkeeping, kept with blocking writes so no step sees two valids
    bit valid_on;
    int burst_left;
    int sent_total;
    int seed_settings;

    // receiver stall pattern
    int stall_left;
    int run_left;
    int quiet_cycles;

    lcg48_bounded_random_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .seed_we    (seed_we),
        .seed_wdata (seed_wdata)
    );

    lcg48_bounded_random_checker i_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .seed_we      (seed_we),
        .seed_wdata   (seed_wdata),
        .fail_count   (fail_count),
        .pending      (pending),
        .result_count (result_count),
        .redraw_count (redraw_count),
        .pow2_count   (pow2_count)
    );

    // 20 ns clock
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // result side: stretches of stalls and of steady ready, lengths at random
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else if (run_left > 0)
        begin
            m_tready <= 1'b1;
            run_left--;
        end
        else
        begin
            stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 50);
            run_left   = $urandom_range(1, 90);
        end
    end

    // watchdog on cycles where neither channel moves an item
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout after %0d quiet cycles", quiet_cycles);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // bound mix: zero, powers of two and one off them, near the top of the range,
    // small and medium sizes up to 2^20, full range, just past 2^30 (redraw-heavy)
    function automatic logic [30:0] rand_bound();
        int k;
        k = $urandom_range(0, 31);
        case ($urandom_range(0, 9))
            0:       return (k == 31) ? 31'd0 : (31'd1 << k);
            1, 2:    return 31'($urandom_range(1, 64));
            3:       return 31'($urandom_range(65, 100000));
            4, 5:    return 31'($urandom());
            6:       return 31'h4000_0000 + 31'($urandom_range(1, 1000));
            7:       return 31'h7FFF_FFFF - 31'($urandom_range(0, 1000));
            8:       return (k >= 31) ? 31'h7FFF_FFFF
                            : ((31'd1 << k) + (($urandom_range(0, 1) == 0) ? 31'd1 : -31'd1));
            default: return 31'($urandom_range(1, 1 << 20));
        endcase
    endfunction

    // seed for each phase after the first: extremes first, then random
    function automatic logic [47:0] phase_seed(input int p);
        case (p)
            1:       return SEED_ALL_ONES;
            2:       return 48'd0;
            3:       return SEED_ZERO_STATE;
            default: return 48'({$urandom(), $urandom()});
        endcase
    endfunction

    // offer one item, hold it until taken; bursts end in a random gap
    task automatic send(input logic [30:0] bound);
        s_tdata  <= {1'b0, bound};
        s_tvalid <= 1'b1;
        valid_on = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        sent_total++;
        burst_left--;
        if (burst_left <= 0)
        begin
            s_tvalid <= 1'b0;
            valid_on = 1'b0;
            repeat ($urandom_range(1, 60)) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
    endtask

    // stop offering and wait for every outstanding value to come back
    task automatic drain();
        if (valid_on)
        begin
            s_tvalid <= 1'b0;
            valid_on = 1'b0;
        end
        do
            @(posedge clk);
        while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_seed(input logic [47:0] seed);
        seed_we    <= 1'b1;
        seed_wdata <= seed;
        @(posedge clk);
        seed_we    <= 1'b0;
        seed_settings++;
    endtask

    initial
    begin
        s_tvalid      = 1'b0;
        s_tdata       = 32'd0;
        m_tready      = 1'b0;
        seed_we       = 1'b0;
        seed_wdata    = 48'd0;
        rst_n         = 1'b0;
        valid_on      = 1'b0;
        sent_total    = 0;
        seed_settings = 1;
        stall_left    = 0;
        run_left      = 0;
        quiet_cycles  = 0;
        burst_left    = $urandom_range(1, 24);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first phase runs on the reset seed
        foreach (CORNER_BOUNDS[i])
            send(CORNER_BOUNDS[i]);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            // seed changes only with the core idle
            if (p > 0)
            begin
                drain();
                write_seed(phase_seed(p));
            end
            repeat (ITEMS_PER_PHASE) send(rand_bound());
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d bound items over %0d seed settings, %0d values checked",
                 sent_total, seed_settings, result_count);
        $display("  %0d power-of-two or zero bounds, %0d rejected draws redrawn",
                 pow2_count, redraw_count);
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/lcgbr_pkg.sv
hw/rtl/lcgbr_dp.sv
hw/rtl/lcgbr_ctrl.sv
hw/rtl/lcg48_bounded_random_core.sv
hw/rtl/lcgbr_checker.sv
test/lcg48_bounded_random_checker.sv
test/tb_lcg48_bounded_random_core.sv
